// File: rtl/qaf_pkg.sv
// Shared types, constants and helper functions of the attitude fusion block.
package qaf_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_STEPS   = 32;

    localparam logic [1:0] REG_PROP  = 2'd0;
    localparam logic [1:0] REG_INTEG = 2'd1;
    localparam logic [1:0] REG_HALF  = 2'd2;
    localparam logic [1:0] REG_YAWSC = 2'd3;

    localparam logic [31:0] RST_PROP  = 32'd322122547;
    localparam logic [31:0] RST_INTEG = 32'd8589935;
    localparam logic [31:0] RST_HALF  = 32'd536871;
    localparam logic [31:0] RST_YAWSC = 32'd1073741824;

    localparam logic signed [35:0] OP_ONE   = 36'sd1;
    localparam logic signed [35:0] OP_2P14  = 36'sd16384;
    localparam logic signed [35:0] OP_Q30   = 36'sd1073741824;
    localparam logic signed [35:0] OP_DEG   = 36'sd961334477;
    localparam logic signed [35:0] HALF_PI  = 36'sd1686629713;

    localparam logic signed [71:0] W_Q30    = 72'sd1073741824;
    localparam logic signed [71:0] W_QMAX   = 72'sd2147483647;
    localparam logic signed [71:0] W_PITCH  = 72'sd5898240;
    localparam logic signed [71:0] W_ROLL   = 72'sd11796480;
    localparam logic signed [71:0] W_S32MAX = 72'sd2147483647;
    localparam logic signed [71:0] W_S32MIN = -72'sd2147483648;
    localparam logic [63:0]        ONE_P60  = 64'h1000_0000_0000_0000;

    // program entry points
    localparam logic [6:0] PC_YAW   = 7'd65;
    localparam logic [6:0] PC_ANGLE = 7'd68;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        K_MAC, K_SQRT, K_DIV, K_CORD, K_END
    } t_kind;

    typedef enum logic [1:0] {
        M_LOAD, M_ADD, M_SUB
    } t_mode;

    typedef enum logic [2:0] {
        SH_0, SH_16, SH_29, SH_30, SH_38
    } t_shift;

    typedef enum logic [4:0] {
        WB_NONE, WB_T, WB_T60, WB_V2X, WB_V1X, WB_E, WB_EI, WB_G, WB_R, WB_RN,
        WB_QN, WB_YAW, WB_S, WB_CY, WB_CX, WB_PITCH, WB_ROLL,
        WB_NRM, WB_NRMQ, WB_AN, WB_Q, WB_Z
    } t_wb;

    typedef struct packed {
        logic        start;
        logic        is_root;
        logic [63:0] val;
        logic [31:0] den;
    } t_rd_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_rd_rsp;

    typedef struct packed {
        logic               start;
        logic signed [35:0] x;
        logic signed [35:0] y;
    } t_cd_req;

    typedef struct packed {
        logic               done;
        logic signed [35:0] z;
    } t_cd_rsp;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:    r = 32'd843314857;
            5'd1:    r = 32'd497837829;
            5'd2:    r = 32'd263043837;
            5'd3:    r = 32'd133525159;
            5'd4:    r = 32'd67021687;
            5'd5:    r = 32'd33543516;
            5'd6:    r = 32'd16775851;
            5'd7:    r = 32'd8388437;
            5'd8:    r = 32'd4194283;
            5'd9:    r = 32'd2097149;
            default: r = 32'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction

    function automatic logic signed [71:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] r;
        if (v > W_S32MAX) r = W_S32MAX;
        else if (v < W_S32MIN) r = W_S32MIN;
        else r = v;
        return r;
    endfunction

    function automatic logic signed [71:0] sat_sym(input logic signed [71:0] v,
                                                   input logic signed [71:0] lim);
        logic signed [71:0] r;
        if (v > lim) r = lim;
        else if (v < -lim) r = -lim;
        else r = v;
        return r;
    endfunction

    function automatic logic signed [35:0] sx32(input logic [31:0] v);
        return {{4{v[31]}}, v};
    endfunction

    function automatic logic signed [35:0] zx32(input logic [31:0] v);
        return {4'b0000, v};
    endfunction

endpackage

// File: rtl/qaf_rootdiv.sv
// Radix-2 shared unit: floor square root of 64 bits or truncating divide by 32 bits.
module qaf_rootdiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qaf_pkg::t_rd_req i_req,
    output qaf_pkg::t_rd_rsp o_rsp
);
    import qaf_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_root;
    logic        r_neg;
    logic [35:0] r_rem;
    logic [31:0] r_res;
    logic [63:0] r_src;
    logic [31:0] r_den;

    logic [63:0] mag;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        fits;

    assign mag = i_req.val[63] ? (~i_req.val + 64'd1) : i_req.val;

    always_comb begin
        if (r_root) begin
            shifted = {r_rem[33:0], r_src[63:62]};
            trial   = {2'b00, r_res, 2'b01};
        end else begin
            shifted = {r_rem[34:0], r_src[63]};
            trial   = {4'b0000, r_den};
        end
        fits = (shifted >= trial);
        diff = shifted - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(ROOT_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_root <= i_req.is_root;
            r_den  <= i_req.den;
            r_res  <= '0;
            if (i_req.is_root) begin
                r_rem <= '0;
                r_src <= i_req.val;
                r_neg <= 1'b0;
            end else begin
                // quotient is known to fit 32 bits, so the top half starts the remainder
                r_rem <= {4'b0000, mag[63:32]};
                r_src <= {mag[31:0], 32'd0};
                r_neg <= i_req.val[63];
            end
        end else if (r_busy) begin
            r_rem <= fits ? diff : shifted;
            r_res <= {r_res[30:0], fits};
            r_src <= r_root ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_neg ? (~r_res + 32'd1) : r_res;

endmodule

// File: rtl/qaf_cordic.sv
// Iterative vectoring CORDIC giving atan2 in Q.30 radians, one rotation per cycle.
module qaf_cordic (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qaf_pkg::t_cd_req i_req,
    output qaf_pkg::t_cd_rsp o_rsp
);
    import qaf_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_i;
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [35:0] r_z;

    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [35:0] ang;
    logic               zero_in;

    assign xs      = r_x >>> r_i;
    assign ys      = r_y >>> r_i;
    assign ang     = zx32(atan_lut(r_i));
    assign zero_in = (i_req.x == '0) && (i_req.y == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_i <= '0;
                if (zero_in) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            if (zero_in) begin
                r_z <= '0;
            end else if (i_req.x < 0) begin
                // quarter-turn prerotation into the right half plane
                if (i_req.y >= 0) begin
                    r_x <= i_req.y;
                    r_y <= -i_req.x;
                    r_z <= HALF_PI;
                end else begin
                    r_x <= -i_req.y;
                    r_y <= i_req.x;
                    r_z <= -HALF_PI;
                end
            end else begin
                r_x <= i_req.x;
                r_y <= i_req.y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.z    = r_z;

endmodule

// File: rtl/quaternion_attitude_fusion.sv
// Top level of the fixed-point quaternion attitude fusion filter.
//
// Usage:
//  - Input channel (i_valid / o_stall): one beat carries a gyro sample (Q16.16 rad/s)
//    and a raw accelerometer sample. o_stall is high while a sample is being worked.
//  - Output channel (o_valid / i_stall): one beat per input beat with pitch (Q8.16) and roll
//    (Q9.16) in degrees, the saturating yaw accumulator and the skipped flag.
//  - Configuration over the APB port: gains, half period and yaw scale at byte
//    addresses 0, 4, 8, 12. Write only while the block is idle. pready is always high.
// Work per sample: a full sample uses the single 36x36 multiplier (68 multiply-accumulate
//  steps), the radix-2 root/divide unit (three roots and seven divides) and the 30-step
//  CORDIC; a sample with a zero accel axis skips the filter update and runs fewer steps.
// The output register frees the engine: a new sample is taken while a result waits.
// If the receiver stalls while a result is still held, the finished sample waits in the
//  engine and no further sample is taken until the output register drains.
// Reset puts the quaternion at (1,0,0,0), clears the integral and yaw, and restores
//  the default register values.
module quaternion_attitude_fusion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_rate_x,
    input  logic signed [31:0] i_rate_y,
    input  logic signed [31:0] i_rate_z,
    input  logic signed [15:0] i_acc_x,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_pitch_deg,
    output logic signed [24:0] o_roll_deg,
    output logic signed [31:0] o_yaw_deg,
    output logic               o_skipped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import qaf_pkg::*;

    // configuration
    logic [31:0] r_prop, r_integ, r_half, r_yawsc;

    // filter state
    logic signed [31:0] r_q  [4];
    logic signed [31:0] r_ei [3];
    logic signed [31:0] r_yaw;

    // sequencer
    t_state      r_state;
    logic [6:0]  r_pc;
    logic        r_phase;
    logic        r_skip;

    // latched sample
    logic signed [31:0] r_rate [3];
    logic signed [15:0] r_acc  [3];

    // scratch registers
    logic signed [31:0] r_an [3];
    logic signed [35:0] r_v  [3];
    logic signed [31:0] r_e  [3];
    logic signed [31:0] r_g  [3];
    logic signed [31:0] r_qn [4];
    logic signed [31:0] r_rr;
    logic signed [31:0] r_s;
    logic signed [35:0] r_cy, r_cx, r_z;
    logic [63:0]        r_t;
    logic [31:0]        r_nrm;
    logic signed [23:0] r_pitch;
    logic signed [24:0] r_roll;

    // multiply-accumulate datapath
    logic signed [71:0] r_prod, r_macc;
    logic signed [71:0] prod_full, prod_sh, acc_next;

    // output register
    logic               r_o_valid;
    logic signed [23:0] r_o_pitch;
    logic signed [24:0] r_o_roll;
    logic signed [31:0] r_o_yaw;
    logic               r_o_skip;

    // current step
    t_kind              kind;
    t_mode              mode;
    t_shift             shift;
    t_wb                wb;
    logic [1:0]         idx;
    logic signed [35:0] op_a, op_b;
    logic [63:0]        rd_val;
    logic signed [35:0] cd_x, cd_y;

    t_rd_req rd_req;
    t_rd_rsp rd_rsp;
    t_cd_req cd_req;
    t_cd_rsp cd_rsp;

    logic in_take, cfg_wr, unit_done, out_free;

    assign in_take  = i_valid && !o_stall;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_PROP:  prdata = r_prop;
            REG_INTEG: prdata = r_integ;
            REG_HALF:  prdata = r_half;
            REG_YAWSC: prdata = r_yawsc;
        endcase
    end

    // microprogram: one step per pc value
    always_comb begin
        kind   = K_MAC;
        mode   = M_LOAD;
        shift  = SH_30;
        wb     = WB_NONE;
        idx    = 2'd0;
        op_a   = '0;
        op_b   = '0;
        rd_val = '0;
        cd_x   = '0;
        cd_y   = '0;
        unique case (r_pc)
            // accel norm and normalized axes
            7'd0:  begin op_a = 36'(r_acc[0]); op_b = 36'(r_acc[0]); shift = SH_0; end
            7'd1:  begin op_a = 36'(r_acc[1]); op_b = 36'(r_acc[1]); shift = SH_0;
                         mode = M_ADD; end
            7'd2:  begin op_a = 36'(r_acc[2]); op_b = 36'(r_acc[2]); shift = SH_0;
                         mode = M_ADD; wb = WB_T; end
            7'd3:  begin kind = K_SQRT; rd_val = {r_t[31:0], 32'd0}; wb = WB_NRM; end
            7'd4:  begin kind = K_DIV; rd_val = {{2{r_acc[0][15]}}, r_acc[0], 46'd0};
                         wb = WB_AN; idx = 2'd0; end
            7'd5:  begin kind = K_DIV; rd_val = {{2{r_acc[1][15]}}, r_acc[1], 46'd0};
                         wb = WB_AN; idx = 2'd1; end
            7'd6:  begin kind = K_DIV; rd_val = {{2{r_acc[2][15]}}, r_acc[2], 46'd0};
                         wb = WB_AN; idx = 2'd2; end
            // estimated gravity
            7'd7:  begin op_a = sx32(r_q[1]); op_b = sx32(r_q[3]); end
            7'd8:  begin op_a = sx32(r_q[0]); op_b = sx32(r_q[2]); mode = M_SUB;
                         wb = WB_V2X; idx = 2'd0; end
            7'd9:  begin op_a = sx32(r_q[0]); op_b = sx32(r_q[1]); end
            7'd10: begin op_a = sx32(r_q[2]); op_b = sx32(r_q[3]); mode = M_ADD;
                         wb = WB_V2X; idx = 2'd1; end
            7'd11: begin op_a = sx32(r_q[0]); op_b = sx32(r_q[0]); end
            7'd12: begin op_a = sx32(r_q[1]); op_b = sx32(r_q[1]); mode = M_SUB; end
            7'd13: begin op_a = sx32(r_q[2]); op_b = sx32(r_q[2]); mode = M_SUB; end
            7'd14: begin op_a = sx32(r_q[3]); op_b = sx32(r_q[3]); mode = M_ADD;
                         wb = WB_V1X; idx = 2'd2; end
            // cross product error
            7'd15: begin op_a = sx32(r_an[1]); op_b = r_v[2]; end
            7'd16: begin op_a = sx32(r_an[2]); op_b = r_v[1]; mode = M_SUB;
                         wb = WB_E; idx = 2'd0; end
            7'd17: begin op_a = sx32(r_an[2]); op_b = r_v[0]; end
            7'd18: begin op_a = sx32(r_an[0]); op_b = r_v[2]; mode = M_SUB;
                         wb = WB_E; idx = 2'd1; end
            7'd19: begin op_a = sx32(r_an[0]); op_b = r_v[1]; end
            7'd20: begin op_a = sx32(r_an[1]); op_b = r_v[0]; mode = M_SUB;
                         wb = WB_E; idx = 2'd2; end
            // integral and corrected rate, x axis
            7'd21: begin op_a = sx32(r_ei[0]); op_b = OP_Q30; end
            7'd22: begin op_a = sx32(r_e[0]); op_b = zx32(r_integ); mode = M_ADD;
                         wb = WB_EI; idx = 2'd0; end
            7'd23: begin op_a = sx32(r_rate[0]); op_b = OP_2P14; shift = SH_0; end
            7'd24: begin op_a = sx32(r_e[0]); op_b = zx32(r_prop); mode = M_ADD; end
            7'd25: begin op_a = sx32(r_ei[0]); op_b = OP_Q30; mode = M_ADD;
                         wb = WB_G; idx = 2'd0; end
            // y axis
            7'd26: begin op_a = sx32(r_ei[1]); op_b = OP_Q30; end
            7'd27: begin op_a = sx32(r_e[1]); op_b = zx32(r_integ); mode = M_ADD;
                         wb = WB_EI; idx = 2'd1; end
            7'd28: begin op_a = sx32(r_rate[1]); op_b = OP_2P14; shift = SH_0; end
            7'd29: begin op_a = sx32(r_e[1]); op_b = zx32(r_prop); mode = M_ADD; end
            7'd30: begin op_a = sx32(r_ei[1]); op_b = OP_Q30; mode = M_ADD;
                         wb = WB_G; idx = 2'd1; end
            // z axis
            7'd31: begin op_a = sx32(r_ei[2]); op_b = OP_Q30; end
            7'd32: begin op_a = sx32(r_e[2]); op_b = zx32(r_integ); mode = M_ADD;
                         wb = WB_EI; idx = 2'd2; end
            7'd33: begin op_a = sx32(r_rate[2]); op_b = OP_2P14; shift = SH_0; end
            7'd34: begin op_a = sx32(r_e[2]); op_b = zx32(r_prop); mode = M_ADD; end
            7'd35: begin op_a = sx32(r_ei[2]); op_b = OP_Q30; mode = M_ADD;
                         wb = WB_G; idx = 2'd2; end
            // quaternion rate, component 0 (negated sum)
            7'd36: begin op_a = sx32(r_q[1]); op_b = sx32(r_g[0]); end
            7'd37: begin op_a = sx32(r_q[2]); op_b = sx32(r_g[1]); mode = M_ADD; end
            7'd38: begin op_a = sx32(r_q[3]); op_b = sx32(r_g[2]); mode = M_ADD;
                         wb = WB_RN; end
            7'd39: begin op_a = sx32(r_rr); op_b = zx32(r_half); shift = SH_16; end
            7'd40: begin op_a = sx32(r_q[0]); op_b = OP_ONE; shift = SH_0; mode = M_ADD;
                         wb = WB_QN; idx = 2'd0; end
            // component 1
            7'd41: begin op_a = sx32(r_q[0]); op_b = sx32(r_g[0]); end
            7'd42: begin op_a = sx32(r_q[2]); op_b = sx32(r_g[2]); mode = M_ADD; end
            7'd43: begin op_a = sx32(r_q[3]); op_b = sx32(r_g[1]); mode = M_SUB;
                         wb = WB_R; end
            7'd44: begin op_a = sx32(r_rr); op_b = zx32(r_half); shift = SH_16; end
            7'd45: begin op_a = sx32(r_q[1]); op_b = OP_ONE; shift = SH_0; mode = M_ADD;
                         wb = WB_QN; idx = 2'd1; end
            // component 2
            7'd46: begin op_a = sx32(r_q[0]); op_b = sx32(r_g[1]); end
            7'd47: begin op_a = sx32(r_q[1]); op_b = sx32(r_g[2]); mode = M_SUB; end
            7'd48: begin op_a = sx32(r_q[3]); op_b = sx32(r_g[0]); mode = M_ADD;
                         wb = WB_R; end
            7'd49: begin op_a = sx32(r_rr); op_b = zx32(r_half); shift = SH_16; end
            7'd50: begin op_a = sx32(r_q[2]); op_b = OP_ONE; shift = SH_0; mode = M_ADD;
                         wb = WB_QN; idx = 2'd2; end
            // component 3
            7'd51: begin op_a = sx32(r_q[0]); op_b = sx32(r_g[2]); end
            7'd52: begin op_a = sx32(r_q[1]); op_b = sx32(r_g[1]); mode = M_ADD; end
            7'd53: begin op_a = sx32(r_q[2]); op_b = sx32(r_g[0]); mode = M_SUB;
                         wb = WB_R; end
            7'd54: begin op_a = sx32(r_rr); op_b = zx32(r_half); shift = SH_16; end
            7'd55: begin op_a = sx32(r_q[3]); op_b = OP_ONE; shift = SH_0; mode = M_ADD;
                         wb = WB_QN; idx = 2'd3; end
            // renormalize
            7'd56: begin op_a = sx32(r_qn[0]); op_b = sx32(r_qn[0]); shift = SH_0; end
            7'd57: begin op_a = sx32(r_qn[1]); op_b = sx32(r_qn[1]); shift = SH_0;
                         mode = M_ADD; end
            7'd58: begin op_a = sx32(r_qn[2]); op_b = sx32(r_qn[2]); shift = SH_0;
                         mode = M_ADD; end
            7'd59: begin op_a = sx32(r_qn[3]); op_b = sx32(r_qn[3]); shift = SH_0;
                         mode = M_ADD; wb = WB_T; end
            7'd60: begin kind = K_SQRT; rd_val = r_t; wb = WB_NRMQ; end
            7'd61: begin kind = K_DIV; rd_val = {{2{r_qn[0][31]}}, r_qn[0], 30'd0};
                         wb = WB_Q; idx = 2'd0; end
            7'd62: begin kind = K_DIV; rd_val = {{2{r_qn[1][31]}}, r_qn[1], 30'd0};
                         wb = WB_Q; idx = 2'd1; end
            7'd63: begin kind = K_DIV; rd_val = {{2{r_qn[2][31]}}, r_qn[2], 30'd0};
                         wb = WB_Q; idx = 2'd2; end
            7'd64: begin kind = K_DIV; rd_val = {{2{r_qn[3][31]}}, r_qn[3], 30'd0};
                         wb = WB_Q; idx = 2'd3; end
            // yaw
            7'd65: begin op_a = sx32(r_rate[2]); op_b = zx32(r_yawsc); wb = WB_R; end
            7'd66: begin op_a = sx32(r_rr); op_b = zx32(r_half); shift = SH_29; end
            7'd67: begin op_a = sx32(r_yaw); op_b = OP_ONE; shift = SH_0; mode = M_ADD;
                         wb = WB_YAW; end
            // pitch
            7'd68: begin op_a = sx32(r_q[0]); op_b = sx32(r_q[2]); end
            7'd69: begin op_a = sx32(r_q[1]); op_b = sx32(r_q[3]); mode = M_SUB;
                         wb = WB_S; end
            7'd70: begin op_a = sx32(r_s); op_b = sx32(r_s); shift = SH_0; wb = WB_T60; end
            7'd71: begin kind = K_SQRT; rd_val = r_t; wb = WB_NRM; end
            7'd72: begin kind = K_CORD; cd_y = sx32(r_s); cd_x = zx32(r_nrm); wb = WB_Z; end
            7'd73: begin op_a = r_z; op_b = OP_DEG; shift = SH_38; wb = WB_PITCH; end
            // roll
            7'd74: begin op_a = sx32(r_q[2]); op_b = sx32(r_q[3]); end
            7'd75: begin op_a = sx32(r_q[0]); op_b = sx32(r_q[1]); mode = M_ADD;
                         wb = WB_CY; end
            7'd76: begin op_a = sx32(r_q[1]); op_b = sx32(r_q[1]); end
            7'd77: begin op_a = sx32(r_q[2]); op_b = sx32(r_q[2]); mode = M_ADD;
                         wb = WB_CX; end
            7'd78: begin kind = K_CORD; cd_y = r_cy; cd_x = r_cx; wb = WB_Z; end
            7'd79: begin op_a = r_z; op_b = OP_DEG; shift = SH_38; wb = WB_ROLL; end
            default: kind = K_END;
        endcase
    end

    // shared multiplier, floor shift
    assign prod_full = op_a * op_b;

    always_comb begin
        unique case (shift)
            SH_0:    prod_sh = prod_full;
            SH_16:   prod_sh = prod_full >>> 16;
            SH_29:   prod_sh = prod_full >>> 29;
            SH_30:   prod_sh = prod_full >>> 30;
            SH_38:   prod_sh = prod_full >>> 38;
            default: prod_sh = prod_full;
        endcase
    end

    always_comb begin
        unique case (mode)
            M_LOAD:  acc_next = r_prod;
            M_ADD:   acc_next = r_macc + r_prod;
            M_SUB:   acc_next = r_macc - r_prod;
            default: acc_next = r_prod;
        endcase
    end

    assign rd_req.start   = (r_state == S_RUN) && ((kind == K_SQRT) || (kind == K_DIV));
    assign rd_req.is_root = (kind == K_SQRT);
    assign rd_req.val     = rd_val;
    assign rd_req.den     = r_nrm;

    assign cd_req.start = (r_state == S_RUN) && (kind == K_CORD);
    assign cd_req.x     = cd_x;
    assign cd_req.y     = cd_y;

    assign unit_done = (kind == K_CORD) ? cd_rsp.done : rd_rsp.done;

    qaf_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rd_req),
        .o_rsp   (rd_rsp)
    );

    qaf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cd_req),
        .o_rsp   (cd_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_phase   <= 1'b0;
            r_o_valid <= 1'b0;
            r_prop    <= RST_PROP;
            r_integ   <= RST_INTEG;
            r_half    <= RST_HALF;
            r_yawsc   <= RST_YAWSC;
            r_q[0]    <= 32'sd1073741824;
            r_q[1]    <= '0;
            r_q[2]    <= '0;
            r_q[3]    <= '0;
            r_ei[0]   <= '0;
            r_ei[1]   <= '0;
            r_ei[2]   <= '0;
            r_yaw     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_PROP:  r_prop  <= pwdata;
                    REG_INTEG: r_integ <= pwdata;
                    REG_HALF:  r_half  <= pwdata;
                    REG_YAWSC: r_yawsc <= pwdata;
                endcase
            end

            if (r_o_valid && !i_stall) r_o_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_rate[0] <= i_rate_x;
                        r_rate[1] <= i_rate_y;
                        r_rate[2] <= i_rate_z;
                        r_acc[0]  <= i_acc_x;
                        r_acc[1]  <= i_acc_y;
                        r_acc[2]  <= i_acc_z;
                        r_skip    <= (i_acc_x == '0) || (i_acc_y == '0) || (i_acc_z == '0);
                        // a zero axis leaves the state alone and goes straight to angles
                        if ((i_acc_x == '0) || (i_acc_y == '0) || (i_acc_z == '0))
                            r_pc <= PC_ANGLE;
                        else
                            r_pc <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    unique case (kind)
                        K_MAC: begin
                            if (!r_phase) begin
                                r_prod  <= prod_sh;
                                r_phase <= 1'b1;
                            end else begin
                                r_macc  <= acc_next;
                                r_phase <= 1'b0;
                                r_pc    <= r_pc + 7'd1;
                                unique case (wb)
                                    WB_T:     r_t <= acc_next[63:0];
                                    WB_T60:   r_t <= ONE_P60 - acc_next[63:0];
                                    WB_V2X:   r_v[idx] <= acc_next[34:0] * 2;
                                    WB_V1X:   r_v[idx] <= acc_next[35:0];
                                    WB_E:     r_e[idx] <= sat32(acc_next)[31:0];
                                    WB_EI:    r_ei[idx] <= sat32(acc_next)[31:0];
                                    WB_G:     r_g[idx] <= sat32(acc_next >>> 14)[31:0];
                                    WB_R:     r_rr <= sat32(acc_next)[31:0];
                                    WB_RN:    r_rr <= sat32(-acc_next)[31:0];
                                    WB_QN:    r_qn[idx] <= sat_sym(acc_next, W_QMAX)[31:0];
                                    WB_YAW:   r_yaw <= sat32(acc_next)[31:0];
                                    WB_S:     r_s <= sat_sym(acc_next <<< 1, W_Q30)[31:0];
                                    WB_CY:    r_cy <= acc_next[34:0] * 2;
                                    WB_CX:    r_cx <= 36'(W_Q30 - (acc_next <<< 1));
                                    WB_PITCH: r_pitch <= sat_sym(acc_next, W_PITCH)[23:0];
                                    WB_ROLL:  r_roll <= sat_sym(acc_next, W_ROLL)[24:0];
                                    default:  ;
                                endcase
                            end
                        end
                        K_SQRT, K_DIV, K_CORD: r_state <= S_WAIT;
                        default: r_state <= S_OUT;
                    endcase
                end
                S_WAIT: begin
                    if (unit_done) begin
                        r_state <= S_RUN;
                        r_pc    <= r_pc + 7'd1;
                        unique case (wb)
                            WB_NRM:  r_nrm <= rd_rsp.result;
                            WB_NRMQ: begin
                                r_nrm <= rd_rsp.result;
                                // degenerate quaternion: keep the old one
                                if (rd_rsp.result == '0) r_pc <= PC_YAW;
                            end
                            WB_AN:   r_an[idx] <= rd_rsp.result;
                            WB_Q:    r_q[idx] <= rd_rsp.result;
                            WB_Z:    r_z <= cd_rsp.z;
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_pitch <= r_pitch;
                        r_o_roll  <= r_roll;
                        r_o_yaw   <= r_yaw;
                        r_o_skip  <= r_skip;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_pitch_deg = r_o_pitch;
    assign o_roll_deg  = r_o_roll;
    assign o_yaw_deg   = r_o_yaw;
    assign o_skipped   = r_o_skip;

    // a unit reports done only while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_rsp.done || cd_rsp.done) |-> (r_state == S_WAIT))
        else $error("shared unit finished outside a wait step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (kind != K_MAC))
        else $error("waiting on a multiply step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result beat not from the output step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_skip) |=> $stable(r_yaw))
        else $error("yaw changed on a skipped sample");

endmodule

// File: test/tb_quaternion_attitude_fusion.sv
// Testbench for quaternion_attitude_fusion: directed table plus random IMU samples,
// every result checked against an in-bench fixed-point model of the filter.
module tb_quaternion_attitude_fusion;
    import qaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one IMU sample and one attitude result, at the port widths
    typedef struct packed {
        logic signed [31:0] rx, ry, rz;
        logic signed [15:0] ax, ay, az;
    } imu_t;

    typedef struct packed {
        logic signed [23:0] pitch;
        logic signed [24:0] roll;
        logic signed [31:0] yaw;
        logic               skip;
    } att_t;

    // directed row: sample plus the skip flag typed in by hand
    typedef struct packed {
        imu_t s;
        logic skip;
    } row_t;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint HPI_Q30 = 64'sd1686629713;
    localparam longint DEG_Q24 = 64'sd961334477;
    localparam longint QMAX    = 64'sd2147483647;
    localparam longint S32MAX  = 64'sd2147483647;
    localparam longint S32MIN  = -64'sd2147483648;

    localparam longint ATAN_Q30 [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_rate_x, i_rate_y, i_rate_z;
    logic signed [15:0] i_acc_x, i_acc_y, i_acc_z;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [23:0] o_pitch_deg;
    logic signed [24:0] o_roll_deg;
    logic signed [31:0] o_yaw_deg;
    logic               o_skipped;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    quaternion_attitude_fusion DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_rate_x   (i_rate_x),
        .i_rate_y   (i_rate_y),
        .i_rate_z   (i_rate_z),
        .i_acc_x    (i_acc_x),
        .i_acc_y    (i_acc_y),
        .i_acc_z    (i_acc_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pitch_deg(o_pitch_deg),
        .o_roll_deg (o_roll_deg),
        .o_yaw_deg  (o_yaw_deg),
        .o_skipped  (o_skipped),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // model copy of the filter state and registers
    int          att_q [4];
    int          err_int [3];
    int          yaw_acc;
    logic [31:0] kp_reg, ki_reg, hp_reg, yscale_reg;

    att_t attitude_q [$];   // results still owed by the block
    int   errors = 0;

    // idle odds in percent, changed per phase by the main flow
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- fixed-point helpers ----------------
    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clamp32(longint v);
        return clamp(v, S32MIN, S32MAX);
    endfunction

    // Q2.30 product, floor
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // vectoring CORDIC, quarter-turn prerotation when x is negative
    function automatic longint atan2_q30(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HPI_Q30;
            end else begin
                t = x; x = -y; y = t; z = -HPI_Q30;
            end
        end
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_Q30[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_Q30[i];
            end
        end
        return z;
    endfunction

    function automatic longint deg_q16(longint rad);
        return (rad * DEG_Q24) >>> 38;
    endfunction

    // One filter step: updates the model state, returns the attitude result.
    function automatic att_t fuse_sample(imu_t s);
        longint rate [3], acc [3], q [4], an [3], v [3], e [3], g [3], r [4], qn [4];
        longint half, ie, d, gz, sn, cs, y, x, pitch, roll;
        longint unsigned ss, nrm;
        logic skip;
        att_t res;
        rate[0] = s.rx; rate[1] = s.ry; rate[2] = s.rz;
        acc[0] = s.ax;  acc[1] = s.ay;  acc[2] = s.az;
        skip = (acc[0] == 0 || acc[1] == 0 || acc[2] == 0);
        if (!skip) begin
            half = longint'(hp_reg);
            ss = 0;
            for (int i = 0; i < 3; i++) ss = ss + longint'(acc[i] * acc[i]);
            nrm = root64(ss << 32);
            for (int i = 0; i < 3; i++) an[i] = (acc[i] * (64'sd1 <<< 46)) / longint'(nrm);
            for (int i = 0; i < 4; i++) q[i] = att_q[i];

            // gravity direction from the current attitude
            v[0] = 2 * (qmul(q[1], q[3]) - qmul(q[0], q[2]));
            v[1] = 2 * (qmul(q[0], q[1]) + qmul(q[2], q[3]));
            v[2] = qmul(q[0], q[0]) - qmul(q[1], q[1]) - qmul(q[2], q[2]) + qmul(q[3], q[3]);

            e[0] = clamp32(qmul(an[1], v[2]) - qmul(an[2], v[1]));
            e[1] = clamp32(qmul(an[2], v[0]) - qmul(an[0], v[2]));
            e[2] = clamp32(qmul(an[0], v[1]) - qmul(an[1], v[0]));

            for (int i = 0; i < 3; i++) begin
                ie = clamp32(longint'(err_int[i]) + qmul(e[i], longint'(ki_reg)));
                err_int[i] = int'(ie);
                g[i] = clamp32((rate[i] * 16384 + qmul(e[i], longint'(kp_reg)) + ie) >>> 14);
            end

            r[0] = -qmul(q[1], g[0]) - qmul(q[2], g[1]) - qmul(q[3], g[2]);
            r[1] = qmul(q[0], g[0]) + qmul(q[2], g[2]) - qmul(q[3], g[1]);
            r[2] = qmul(q[0], g[1]) - qmul(q[1], g[2]) + qmul(q[3], g[0]);
            r[3] = qmul(q[0], g[2]) + qmul(q[1], g[1]) - qmul(q[2], g[0]);

            ss = 0;
            for (int i = 0; i < 4; i++) begin
                d = (clamp32(r[i]) * half) >>> 16;
                qn[i] = clamp(q[i] + d, -QMAX, QMAX);
                ss = ss + longint'(qn[i] * qn[i]);
            end
            nrm = root64(ss);
            // degenerate integration keeps the old quaternion
            if (nrm != 0)
                for (int i = 0; i < 4; i++) att_q[i] = int'((qn[i] * ONE_Q30) / longint'(nrm));

            gz = clamp32(qmul(rate[2], longint'(yscale_reg)));
            yaw_acc = int'(clamp32(longint'(yaw_acc) + ((gz * half) >>> 29)));
        end

        for (int i = 0; i < 4; i++) q[i] = att_q[i];
        sn = clamp(2 * (qmul(q[0], q[2]) - qmul(q[1], q[3])), -ONE_Q30, ONE_Q30);
        cs = longint'(root64(longint'(ONE_Q30 * ONE_Q30 - sn * sn)));
        pitch = clamp(deg_q16(atan2_q30(sn, cs)), -64'sd5898240, 64'sd5898240);
        y = 2 * (qmul(q[2], q[3]) + qmul(q[0], q[1]));
        x = ONE_Q30 - 2 * (qmul(q[1], q[1]) + qmul(q[2], q[2]));
        roll = clamp(deg_q16(atan2_q30(y, x)), -64'sd11796480, 64'sd11796480);

        res.pitch = pitch[23:0];
        res.roll  = roll[24:0];
        res.yaw   = yaw_acc;
        res.skip  = skip;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic row_t mk_row(int rx, int ry, int rz, shortint ax, shortint ay,
                                    shortint az, logic skip);
        row_t w;
        w.s = {rx, ry, rz, ax, ay, az};
        w.skip = skip;
        return w;
    endfunction

    // mostly plausible motion, some full-range rates, some dead accel axes
    function automatic imu_t rand_sample();
        imu_t s;
        logic signed [31:0] rt [3];
        logic signed [15:0] ac [3];
        for (int i = 0; i < 3; i++) begin
            rt[i] = $urandom();
            if ($urandom_range(99) < 80) rt[i] = rt[i] >>> $urandom_range(8, 15);
            ac[i] = $urandom();
            if ($urandom_range(99) < 30) ac[i] = ac[i] >>> $urandom_range(1, 14);
        end
        if ($urandom_range(99) < 8) ac[$urandom_range(2)] = '0;
        s = {rt[0], rt[1], rt[2], ac[0], ac[1], ac[2]};
        return s;
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP:  kp_reg = val;
            REG_INTEG: ki_reg = val;
            REG_HALF:  hp_reg = val;
            default:   yscale_reg = val;
        endcase
    endtask

    task automatic set_regs(logic [31:0] kp, logic [31:0] ki, logic [31:0] hp,
                            logic [31:0] ys);
        reg_write(REG_PROP, kp);
        reg_write(REG_INTEG, ki);
        reg_write(REG_HALF, hp);
        reg_write(REG_YAWSC, ys);
    endtask

    // Offer one beat and hold it until taken; returns at the accepting edge or after a sender gap.
    task automatic push_sample(imu_t s, logic typed, logic skip);
        att_t a;
        i_valid  <= 1'b1;
        i_rate_x <= s.rx;
        i_rate_y <= s.ry;
        i_rate_z <= s.rz;
        i_acc_x  <= s.ax;
        i_acc_y  <= s.ay;
        i_acc_z  <= s.az;
        do @(posedge i_clk); while (o_stall);
        a = fuse_sample(s);
        if (typed) a.skip = skip;
        attitude_q.push_back(a);
        // sometimes a sender gap with i_valid low
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (attitude_q.size() != 0) @(posedge i_clk);
        // the block finishes its own bookkeeping before config is touched
        repeat (20) @(posedge i_clk);
    endtask

    // ---------------- receiver: random stall plus one long hold-off ----------------
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        att_t x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (attitude_q.size() == 0) begin
                $display("%t unexpected result beat: pitch %0d roll %0d yaw %0d skip %0b",
                         $realtime, o_pitch_deg, o_roll_deg, o_yaw_deg, o_skipped);
                errors <= errors + 1;
            end else begin
                x = attitude_q.pop_front();
                if (o_pitch_deg !== x.pitch) begin
                    $display("%t pitch: expected %0d, got %0d", $realtime, x.pitch, o_pitch_deg);
                    errors <= errors + 1;
                end
                if (o_roll_deg !== x.roll) begin
                    $display("%t roll: expected %0d, got %0d", $realtime, x.roll, o_roll_deg);
                    errors <= errors + 1;
                end
                if (o_yaw_deg !== x.yaw) begin
                    $display("%t yaw: expected %0d, got %0d", $realtime, x.yaw, o_yaw_deg);
                    errors <= errors + 1;
                end
                if (o_skipped !== x.skip) begin
                    $display("%t skipped: expected %0b, got %0b", $realtime, x.skip, o_skipped);
                    errors <= errors + 1;
                end
            end
        end
    end

    // ---------------- main flow ----------------
    initial begin
        row_t dir_tab [$];
        logic [31:0] cfg_tab [6][4];
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_rate_x = '0; i_rate_y = '0; i_rate_z = '0;
        i_acc_x  = '0; i_acc_y  = '0; i_acc_z  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;

        att_q = '{int'(ONE_Q30), 0, 0, 0};
        err_int = '{0, 0, 0};
        yaw_acc = 0;
        kp_reg = RST_PROP; ki_reg = RST_INTEG; hp_reg = RST_HALF; yscale_reg = RST_YAWSC;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; skip flag typed in, the rest from the model
        dir_tab.push_back(mk_row(0, 0, 0, 0, 0, 0, 1'b1));                  // nothing yet
        dir_tab.push_back(mk_row(65536, 0, 0, 0, 100, 100, 1'b1));          // x axis dead
        dir_tab.push_back(mk_row(0, 65536, 0, 100, 0, 100, 1'b1));          // y axis dead
        dir_tab.push_back(mk_row(0, 0, 65536, 100, 100, 0, 1'b1));          // z axis dead
        dir_tab.push_back(mk_row(0, 0, 0, 1, 1, 16384, 1'b0));              // level, at rest
        dir_tab.push_back(mk_row(0, 0, 0, 1, 1, 1, 1'b0));                  // tiny accel
        dir_tab.push_back(mk_row(0, 0, 0, 32767, 32767, 32767, 1'b0));
        dir_tab.push_back(mk_row(0, 0, 0, -32768, -32768, -32768, 1'b0));
        dir_tab.push_back(mk_row(0, 0, 0, -32768, 1, 1, 1'b0));             // sideways
        dir_tab.push_back(mk_row(0, 0, 0, 1, -32768, 1, 1'b0));
        dir_tab.push_back(mk_row(0, 0, 0, 1, 1, -32768, 1'b0));             // upside down
        dir_tab.push_back(mk_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                 1000, 1000, 1000, 1'b0));                  // rates at max
        dir_tab.push_back(mk_row(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                 -1000, 1000, -1000, 1'b0));                // rates at min
        dir_tab.push_back(mk_row(32'sh7fffffff, 0, 32'sh80000000, 1, 1, 1, 1'b0));
        dir_tab.push_back(mk_row(205887, 0, 0, 100, 2000, 16000, 1'b0));    // pi rad/s roll
        dir_tab.push_back(mk_row(0, -205887, 0, -3000, 100, 16000, 1'b0));
        dir_tab.push_back(mk_row(0, 0, 102943, 50, -50, 16384, 1'b0));
        dir_tab.push_back(mk_row(32'sh7fffffff, 0, 0, 0, 0, 0, 1'b1));      // all dead
        dir_tab.push_back(mk_row(0, 0, 0, 16384, 16384, 1, 1'b0));
        dir_tab.push_back(mk_row(-1, -1, -1, -1, -1, -1, 1'b0));
        tx_idle_pct = 34;
        rx_idle_pct = 85;
        foreach (dir_tab[k]) push_sample(dir_tab[k].s, 1'b1, dir_tab[k].skip);
        i_valid <= 1'b0;
        drain();

        // register settings per random phase: defaults, zero, all ones, typical, random, defaults again
        cfg_tab[0] = '{RST_PROP, RST_INTEG, RST_HALF, RST_YAWSC};
        cfg_tab[1] = '{32'h0, 32'h0, 32'h0, 32'h0};
        cfg_tab[2] = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
        cfg_tab[3] = '{32'd1073741824, 32'd107374182, 32'd5368709, 32'd536870912};
        cfg_tab[4] = '{$urandom(), $urandom(), $urandom() >> 8, $urandom()};
        cfg_tab[5] = '{RST_PROP, RST_INTEG, RST_HALF, RST_YAWSC};

        for (int ph = 0; ph < 6; ph++) begin
            set_regs(cfg_tab[ph][0], cfg_tab[ph][1], cfg_tab[ph][2], cfg_tab[ph][3]);
            // first sender-light/receiver-heavy, then reversed, then flat out
            tx_idle_pct = (ph < 2) ? 34 : (ph < 4) ? 85 : 0;
            rx_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 34 : 0;
            if (ph == 4) hold_go = 1'b1;   // long receiver hold-off, block backs up
            repeat (300) push_sample(rand_sample(), 1'b0, 1'b0);
            i_valid <= 1'b0;
            drain();
        end

        repeat (600) @(posedge i_clk);
        if (errors == 0 && attitude_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
